@@ hdl/rssd_pkg.sv @@
// shared types, constants and lookup functions of the rotating counter display
`default_nettype none

package rssd_pkg;

  // display geometry
  localparam int unsigned NumDigits = 6;
  localparam int unsigned CntW      = $clog2(NumDigits + 1);

  // counter registers and their indexes on the configuration port
  localparam int unsigned NumRegs  = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned RegHeadToHead    = 0;
  localparam int unsigned RegSolo          = 1;
  localparam int unsigned RegDailyUsers    = 2;
  localparam int unsigned RegOnlineUsers   = 3;
  localparam int unsigned RegCharacters    = 4;

  // page codes
  localparam logic [2:0] PageHeadToHead  = 3'd0;
  localparam logic [2:0] PageBanner      = 3'd1;
  localparam logic [2:0] PageSolo        = 3'd2;
  localparam logic [2:0] PageDailyUsers  = 3'd3;
  localparam logic [2:0] PageOnlineUsers = 3'd4;
  localparam logic [2:0] PageCharacters  = 3'd5;

  // reciprocal constants: floor(n/1000) for 32 bit n
  localparam logic [31:0] MsRecip     = 32'h1062_4DD3;
  localparam int unsigned MsShift     = 38;
  // floor(n/36) for n below 2^23
  localparam logic [22:0] Div36Recip  = 23'd7456541;
  localparam int unsigned Div36Shift  = 28;
  // floor(n/10) for 32 bit n
  localparam logic [31:0] Div10Recip  = 32'hCCCC_CCCD;
  localparam int unsigned Div10Shift  = 35;

  typedef logic [NumRegs-1:0][31:0] counters_t;

  // one item handed from the page pipeline to the digit serialiser
  typedef struct packed {
    logic        valid;
    logic [2:0]  page;
    logic [31:0] value;
  } rssd_item_t;

  // decimal digit to segment mask
  function automatic logic [6:0] digit_seg(input logic [3:0] d);
    logic [6:0] m;
    case (d)
      4'd0:    m = 7'h77;
      4'd1:    m = 7'h11;
      4'd2:    m = 7'h6B;
      4'd3:    m = 7'h3B;
      4'd4:    m = 7'h1D;
      4'd5:    m = 7'h3E;
      4'd6:    m = 7'h7E;
      4'd7:    m = 7'h13;
      4'd8:    m = 7'h7F;
      4'd9:    m = 7'h3F;
      default: m = 7'h00;
    endcase
    return m;
  endfunction

  // banner "bt12-3", position 0 is the rightmost character, blank above
  function automatic logic [6:0] banner_seg(input logic [CntW-1:0] pos);
    logic [6:0] m;
    case (32'(pos))
      32'd0:   m = 7'h3B;
      32'd1:   m = 7'h08;
      32'd2:   m = 7'h6B;
      32'd3:   m = 7'h11;
      32'd4:   m = 7'h6C;
      32'd5:   m = 7'h7C;
      default: m = 7'h00;
    endcase
    return m;
  endfunction

  // fixed colour of each page
  function automatic logic [23:0] page_color(input logic [2:0] page);
    logic [23:0] c;
    case (page)
      PageHeadToHead:  c = 24'hFF0000;
      PageBanner:      c = 24'hFF1E00;
      PageSolo:        c = 24'hFF00FF;
      PageDailyUsers:  c = 24'h00FF00;
      PageOnlineUsers: c = 24'hFFFF00;
      PageCharacters:  c = 24'h0000FF;
      default:         c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rotating_seven_segment_counter_display_core.sv @@
// top level: counter registers, command handshake, page pipeline and digit serialiser
// result path: page pipeline, serialiser load register and result register; the beats then follow one per cycle
// each item gives NumDigits (6) beats back to back, the last one flagged
// accepted items are spaced by the gap counter to match the one-digit-per-cycle serialiser
// busy is high while the gap counter, loaded on each accepted start, counts down; the next item is
// taken while the previous one is still being emitted
// reset clears the five counters to zero and empties the pipeline; the result
// side has no back-pressure
`default_nettype none

module rotating_seven_segment_counter_display_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [31:0]                  uptime_ms_i,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [rssd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]                  cfg_data_i,
  output logic                              result_valid_o,
  output logic [2:0]                        digit_position_o,
  output logic [6:0]                        segment_mask_o,
  output logic [23:0]                       drive_color_o,
  output logic [2:0]                        page_shown_o,
  output logic                              last_digit_o
);
  import rssd_pkg::*;

  counters_t       counters_q;
  logic [CntW-1:0] gap_q;
  logic            accept;
  rssd_item_t      item;

  assign cfg_ready_o = 1'b1;
  assign busy        = (gap_q != '0);
  assign accept      = start && !busy;

  // counter registers, writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counters_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i < CfgIdxW'(NumRegs))) begin
      counters_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // spacing between accepted items matches the serialiser's beat count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
    end else if (accept) begin
      gap_q <= CntW'(NumDigits - 1);
    end else if (gap_q != '0) begin
      gap_q <= gap_q - CntW'(1);
    end
  end

  rssd_page_pipe u_page_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .uptime_ms_i (uptime_ms_i),
    .counters_i  (counters_q),
    .item_o      (item)
  );

  rssd_digit_ser u_digit_ser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item),
    .result_valid_o   (result_valid_o),
    .digit_position_o (digit_position_o),
    .segment_mask_o   (segment_mask_o),
    .drive_color_o    (drive_color_o),
    .page_shown_o     (page_shown_o),
    .last_digit_o     (last_digit_o)
  );

  // checks
  a_last_at_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_digit_o |-> digit_position_o == 3'(NumDigits - 1))
    else $error("last beat not at top digit position");

  a_frame_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_digit_o |=> result_valid_o)
    else $error("frame broken before its last beat");

  a_page_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> page_shown_o <= PageCharacters)
    else $error("page index out of range");

  a_item_not_overlapping: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item.valid |-> !$past(item.valid))
    else $error("serialiser loaded twice in a row");

endmodule

`default_nettype wire

@@ hdl/rssd_page_pipe.sv @@
// three stage pipeline from timestamp to page index and selected counter
`default_nettype none

module rssd_page_pipe (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic [31:0]         uptime_ms_i,
  input  wire rssd_pkg::counters_t counters_i,
  output rssd_pkg::rssd_item_t     item_o
);
  import rssd_pkg::*;

  logic        s1_valid_q;
  logic [60:0] s1_prod_q;
  logic        s2_valid_q;
  logic [22:0] s2_sec_q;
  logic [45:0] s2_prod_q;
  logic        s3_valid_q;
  logic [2:0]  s3_page_q;
  logic [31:0] s3_value_q;

  logic [22:0] sec_d;
  logic [17:0] q36;
  logic [22:0] q36_x36;
  logic [5:0]  sec_mod36;
  logic [11:0] page_scaled;
  logic [2:0]  page_d;
  logic [31:0] value_d;

  // stage 1: seconds as a reciprocal product
  // stage 2: seconds divided by 36 as a reciprocal product
  assign sec_d = s1_prod_q[MsShift +: 23];

  // stage 3: remainder mod 36, then page = remainder / 6 via multiply by 43 >> 8
  always_comb begin
    q36         = s2_prod_q[Div36Shift +: 18];
    q36_x36     = (23'(q36) << 5) + (23'(q36) << 2);
    sec_mod36   = 6'(s2_sec_q - q36_x36);
    page_scaled = (12'(sec_mod36) << 5) + (12'(sec_mod36) << 3)
                + (12'(sec_mod36) << 1) + 12'(sec_mod36);
    page_d      = page_scaled[10:8];
  end

  // counter shown on the page
  always_comb begin
    case (page_d)
      PageHeadToHead:  value_d = counters_i[RegHeadToHead];
      PageSolo:        value_d = counters_i[RegSolo];
      PageDailyUsers:  value_d = counters_i[RegDailyUsers];
      PageOnlineUsers: value_d = counters_i[RegOnlineUsers];
      PageCharacters:  value_d = counters_i[RegCharacters];
      default:         value_d = 32'd0;
    endcase
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      s1_prod_q <= 61'({32'd0, uptime_ms_i} * {32'd0, MsRecip});
    end
    if (s1_valid_q) begin
      s2_sec_q  <= sec_d;
      s2_prod_q <= 46'({23'd0, sec_d} * {23'd0, Div36Recip});
    end
    if (s2_valid_q) begin
      s3_page_q  <= page_d;
      s3_value_q <= value_d;
    end
  end

  assign item_o.valid = s3_valid_q;
  assign item_o.page  = s3_page_q;
  assign item_o.value = s3_value_q;

endmodule

`default_nettype wire

@@ hdl/rssd_digit_ser.sv @@
// digit serialiser: one decimal digit or banner character per cycle into the registered result port
`default_nettype none

module rssd_digit_ser (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire rssd_pkg::rssd_item_t item_i,
  output logic                      result_valid_o,
  output logic [2:0]                digit_position_o,
  output logic [6:0]                segment_mask_o,
  output logic [23:0]               drive_color_o,
  output logic [2:0]                page_shown_o,
  output logic                      last_digit_o
);
  import rssd_pkg::*;

  logic            ser_active_q;
  logic [31:0]     ser_val_q;
  logic [CntW-1:0] ser_pos_q;
  logic [2:0]      ser_page_q;

  logic            out_valid_q;
  logic [CntW-1:0] out_pos_q;
  logic [6:0]      out_mask_q;
  logic [23:0]     out_color_q;
  logic [2:0]      out_page_q;
  logic            out_last_q;

  logic [63:0]     div_prod;
  logic [31:0]     quo;
  logic [31:0]     rem;
  logic [6:0]      mask_d;
  logic            last_d;

  // value / 10 by reciprocal, low digit is what is left over
  always_comb begin
    div_prod = {32'd0, ser_val_q} * {32'd0, Div10Recip};
    quo      = 32'(div_prod >> Div10Shift);
    rem      = ser_val_q - ((quo << 3) + (quo << 1));
    mask_d   = (ser_page_q == PageBanner) ? banner_seg(ser_pos_q) : digit_seg(rem[3:0]);
    last_d   = (ser_pos_q == CntW'(NumDigits - 1));
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_active_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= ser_active_q;
      if (item_i.valid) begin
        ser_active_q <= 1'b1;
      end else if (ser_active_q && last_d) begin
        ser_active_q <= 1'b0;
      end
    end
  end

  // digit walk and result register; a new load wins over the last digit step
  always_ff @(posedge clk_i) begin
    if (ser_active_q) begin
      out_pos_q   <= ser_pos_q;
      out_mask_q  <= mask_d;
      out_color_q <= page_color(ser_page_q);
      out_page_q  <= ser_page_q;
      out_last_q  <= last_d;
    end
    if (item_i.valid) begin
      ser_val_q  <= item_i.value;
      ser_pos_q  <= '0;
      ser_page_q <= item_i.page;
    end else if (ser_active_q) begin
      ser_val_q  <= quo;
      ser_pos_q  <= ser_pos_q + CntW'(1);
    end
  end

  assign result_valid_o   = out_valid_q;
  assign digit_position_o = 3'(out_pos_q);
  assign segment_mask_o   = out_mask_q;
  assign drive_color_o    = out_color_q;
  assign page_shown_o     = out_page_q;
  assign last_digit_o     = out_last_q;

endmodule

`default_nettype wire
